// ===== rtl/lrn_pkg.sv =====
// Shared constants, register codes and lookup tables for the local response normaliser.
`timescale 1ns / 1ps

package lrn_pkg;

  // Sizes of the sample window and of one sample word.
  localparam int unsigned MaxWindow   = 15;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CfgWidth    = 24;

  // Divider geometry: scaled square sum divided by the window size.
  localparam int unsigned NumWidth     = 58;
  localparam int unsigned DivisorWidth = 4;
  localparam int unsigned DivCntWidth  = $clog2(NumWidth);

  typedef logic signed [SampleWidth-1:0] sample_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgWindow = 2'd0,
    CfgAlpha  = 2'd1,
    CfgBeta   = 2'd2,
    CfgBias   = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [3:0]  WindowReset = 4'd5;
  localparam logic [23:0] AlphaReset  = 24'd1678;
  localparam logic [15:0] BetaReset   = 16'd12288;
  localparam logic [23:0] BiasReset   = 24'd65536;

  // Fractional part of log2 over one octave, Q16, 17 knots.
  function automatic logic [16:0] log_tab(input logic [4:0] idx);
    logic [16:0] val;
    unique case (idx)
      5'd0:    val = 17'd0;
      5'd1:    val = 17'd5732;
      5'd2:    val = 17'd11136;
      5'd3:    val = 17'd16253;
      5'd4:    val = 17'd21098;
      5'd5:    val = 17'd25711;
      5'd6:    val = 17'd30109;
      5'd7:    val = 17'd34312;
      5'd8:    val = 17'd38336;
      5'd9:    val = 17'd42196;
      5'd10:   val = 17'd45904;
      5'd11:   val = 17'd49472;
      5'd12:   val = 17'd52911;
      5'd13:   val = 17'd56229;
      5'd14:   val = 17'd59434;
      5'd15:   val = 17'd62534;
      5'd16:   val = 17'd65536;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

  // 2^f over one octave, Q16, 17 knots.
  function automatic logic [17:0] exp_tab(input logic [4:0] idx);
    logic [17:0] val;
    unique case (idx)
      5'd0:    val = 18'd65536;
      5'd1:    val = 18'd68438;
      5'd2:    val = 18'd71468;
      5'd3:    val = 18'd74632;
      5'd4:    val = 18'd77936;
      5'd5:    val = 18'd81386;
      5'd6:    val = 18'd84990;
      5'd7:    val = 18'd88752;
      5'd8:    val = 18'd92682;
      5'd9:    val = 18'd96785;
      5'd10:   val = 18'd101070;
      5'd11:   val = 18'd105545;
      5'd12:   val = 18'd110218;
      5'd13:   val = 18'd115098;
      5'd14:   val = 18'd120194;
      5'd15:   val = 18'd125515;
      5'd16:   val = 18'd131072;
      default: val = 18'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/local_response_norm_channel.sv =====
// Top level of the cross-channel local response normaliser.
//
// Samples of one spatial position arrive one channel per input word on a
// valid/ready channel; last_channel_i marks the final channel of the vector.
// Normalised samples leave on a valid/ready output channel held in an output
// register, with out_last_o on the final word of the vector.
// Each input word passes through the bookkeeping states idle and decide, then
// one emission pass per result it releases: none or one for an inner channel,
// all held results for the last channel. How long an emission pass runs is set
// by the single shared 24x24 multiplier, which serves the squares, the alpha
// scaling, both table interpolations, the beta product and the final scaling,
// and by the 58-step bit-serial divider.
// The input is not ready while an emission pass runs.
// If the receiver stalls, the finished word waits in the output register and
// the next pass stops in its final step until that word is taken.
// Reset loads the register defaults and empties the window history; the
// sample store itself is not cleared.
`timescale 1ns / 1ps

module local_response_norm_channel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [lrn_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [lrn_pkg::SampleWidth-1:0] in_sample_i,
  input  logic                            last_channel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [lrn_pkg::SampleWidth-1:0] out_sample_o,
  output logic                            out_last_o,
  output logic                            saturated_o
);

  typedef enum logic [19:0] {
    SIdle      = 20'h00001,
    SDecide    = 20'h00002,
    SSetup     = 20'h00004,
    SSumI      = 20'h00008,
    SSumA      = 20'h00010,
    SAlphaLo   = 20'h00020,
    SAlphaHi   = 20'h00040,
    SAlphaAcc  = 20'h00080,
    SDivStart  = 20'h00100,
    SDivWait   = 20'h00200,
    SDen       = 20'h00400,
    SNorm      = 20'h00800,
    SLog       = 20'h01000,
    SBeta      = 20'h02000,
    SQuot      = 20'h04000,
    SExpI      = 20'h08000,
    SExpR      = 20'h10000,
    SMag       = 20'h20000,
    SScale     = 20'h40000,
    SOut       = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [3:0]  win_q;
  logic [23:0] alpha_q;
  logic [15:0] beta_q;
  logic [23:0] bias_q;

  // Control state.
  logic [3:0] pend_q, pend_d;
  logic [3:0] hist_q, hist_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;

  // Datapath registers.
  lrn_pkg::sample_t ring_q [lrn_pkg::MaxWindow];
  logic [3:0]         d_q, d_d;
  logic [3:0]         idx_q, idx_d;
  logic [3:0]         end_q, end_d;
  logic [33:0]        sum_q, sum_d;
  logic [23:0]        mul_a_q, mul_a_d;
  logic [23:0]        mul_b_q, mul_b_d;
  logic [lrn_pkg::NumWidth-1:0] num_q, num_d;
  logic [58:0]        den_q, den_d;
  logic [5:0]         p_q, p_d;
  logic signed [22:0] l_q, l_d;
  logic signed [24:0] q_q, q_d;
  logic [16:0]        e_q, e_d;
  logic [32:0]        mag_q, mag_d;
  logic               zden_q, zden_d;
  logic signed [lrn_pkg::SampleWidth-1:0] out_sample_q, out_sample_d;
  logic               out_last_q, out_last_d;
  logic               out_sat_q, out_sat_d;

  logic               ring_shift;
  logic               div_start;
  logic               div_done;
  logic [lrn_pkg::NumWidth-1:0] div_quo;
  logic [47:0]        prod;

  // Shared multiplier on registered operands.
  assign prod = mul_a_q * mul_b_q;

  // Single read port of the sample store.
  logic [3:0]         rd_idx;
  lrn_pkg::sample_t   ring_rd;
  logic [15:0]        rd_abs;

  always_comb begin
    rd_idx  = (state_q == SSumI) ? idx_q : d_q;
    ring_rd = ring_q[rd_idx];
    rd_abs  = ring_rd[15] ? (~ring_rd + 16'd1) : ring_rd;
  end

  // Window limits for the channel being emitted.
  logic [3:0] n_eff;
  logic [3:0] n_m1;
  logic [2:0] hlo;
  logic [2:0] hhi;
  logic [3:0] below;
  logic [3:0] lo_ext;
  logic [3:0] up_ext;
  logic [4:0] end_sum;
  logic [3:0] end_sel;

  always_comb begin
    n_eff   = (win_q == 4'd0) ? 4'd1 : win_q;
    n_m1    = n_eff - 4'd1;
    hlo     = n_m1[3:1];
    hhi     = n_eff[3:1];
    below   = (hist_q > d_q) ? (hist_q - 4'd1 - d_q) : 4'd0;
    lo_ext  = (below < {1'b0, hlo}) ? below : {1'b0, hlo};
    up_ext  = (d_q < {1'b0, hhi}) ? d_q : {1'b0, hhi};
    end_sum = {1'b0, d_q} + {1'b0, lo_ext};
    end_sel = (end_sum > 5'(lrn_pkg::MaxWindow - 1)) ? 4'(lrn_pkg::MaxWindow - 1)
                                                     : end_sum[3:0];
  end

  // Table interpolation terms.
  logic [3:0]  log_i;
  logic [16:0] log_lo;
  logic [16:0] log_hi;
  logic [16:0] log_diff;
  logic [16:0] lf;
  logic signed [6:0]  p_m40;
  logic signed [22:0] l_abs_s;
  logic [17:0] exp_lo;
  logic [17:0] exp_hi;
  logic [17:0] exp_diff;
  logic [37:0] beta_prod;
  logic        l_pos;
  logic signed [38:0] t_val;

  always_comb begin
    log_i    = den_q[57:54];
    log_lo   = lrn_pkg::log_tab({1'b0, log_i});
    log_hi   = lrn_pkg::log_tab({1'b0, log_i} + 5'd1);
    log_diff = log_hi - log_lo;
    lf       = log_lo + {4'd0, prod[28:16]};
    p_m40    = $signed({1'b0, p_q}) - 7'sd40;
    l_abs_s  = l_q[22] ? -l_q : l_q;
    exp_lo   = lrn_pkg::exp_tab({1'b0, q_q[15:12]});
    exp_hi   = lrn_pkg::exp_tab({1'b0, q_q[15:12]} + 5'd1);
    exp_diff = exp_hi - exp_lo;
    beta_prod = prod[37:0];
    l_pos    = !l_q[22] && (l_q != 23'sd0);
    t_val    = l_pos ? -$signed({1'b0, beta_prod}) : $signed({1'b0, beta_prod});
  end

  // Final scaling by 2^k, rounding and saturation.
  logic [32:0]        mag;
  logic signed [8:0]  k_val;
  logic signed [9:0]  shift_s;
  logic signed [9:0]  neg_s;
  logic [4:0]         shl_amt;
  logic [5:0]         shr_amt;
  logic [33:0]        shr_sum;
  logic [55:0]        m_val;
  logic               m_over;
  logic [16:0]        lim;
  logic [15:0]        m_sat;
  logic signed [15:0] res;
  logic               res_sat;

  always_comb begin
    mag     = mag_q;
    k_val   = q_q[24:16];
    shift_s = 10'sd16 - {k_val[8], k_val};
    neg_s   = -shift_s;
    shl_amt = neg_s[4:0];
    shr_amt = shift_s[5:0];
    shr_sum = {1'b0, mag} + (34'd1 << (shr_amt - 6'd1));
    lim     = ring_rd[15] ? 17'd32768 : 17'd32767;
    m_over  = 1'b0;
    m_val   = '0;
    if (mag == 33'd0) begin
      m_val = '0;
    end else if (shift_s <= 10'sd0) begin
      if (shift_s <= -10'sd24) begin
        m_over = 1'b1;
      end else begin
        m_val = {23'd0, mag} << shl_amt;
      end
    end else if (shift_s >= 10'sd34) begin
      m_val = '0;
    end else begin
      m_val = {22'd0, shr_sum >> shr_amt};
    end
    if (m_over || (m_val > {39'd0, lim})) begin
      m_sat   = lim[15:0];
      res_sat = 1'b1;
    end else begin
      m_sat   = m_val[15:0];
      res_sat = 1'b0;
    end
    res = ring_rd[15] ? $signed(~m_sat + 16'd1) : $signed(m_sat);
    // Zero denominator with a nonzero exponent: clip towards the sign of x.
    if (zden_q) begin
      res_sat = 1'b1;
      if (ring_rd[15]) begin
        res = 16'sh8000;
      end else if (ring_rd != 16'sd0) begin
        res = 16'sh7FFF;
      end else begin
        res = 16'sd0;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    hist_d       = hist_q;
    last_d       = last_q;
    d_d          = d_q;
    idx_d        = idx_q;
    end_d        = end_q;
    sum_d        = sum_q;
    mul_a_d      = mul_a_q;
    mul_b_d      = mul_b_q;
    num_d        = num_q;
    den_d        = den_q;
    p_d          = p_q;
    l_d          = l_q;
    q_d          = q_q;
    e_d          = e_q;
    mag_d        = mag_q;
    zden_d       = zden_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_sat_d    = out_sat_q;
    ring_shift   = 1'b0;
    div_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ring_shift = 1'b1;
          if (hist_q < 4'(lrn_pkg::MaxWindow)) begin
            hist_d = hist_q + 4'd1;
          end
          pend_d  = pend_q + 4'd1;
          last_d  = last_channel_i;
          state_d = SDecide;
        end
      end
      SDecide: begin
        if (last_q || (pend_q > {1'b0, hhi})) begin
          d_d     = pend_q - 4'd1;
          pend_d  = pend_q - 4'd1;
          state_d = SSetup;
        end else begin
          state_d = SIdle;
        end
      end
      SSetup: begin
        idx_d   = d_q - up_ext;
        end_d   = end_sel;
        sum_d   = '0;
        zden_d  = 1'b0;
        state_d = SSumI;
      end
      SSumI: begin
        mul_a_d = {8'd0, rd_abs};
        mul_b_d = {8'd0, rd_abs};
        state_d = SSumA;
      end
      SSumA: begin
        sum_d = sum_q + {2'd0, prod[31:0]};
        if (idx_q == end_q) begin
          state_d = SAlphaLo;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = SSumI;
        end
      end
      SAlphaLo: begin
        mul_a_d = alpha_q;
        mul_b_d = {7'd0, sum_q[16:0]};
        state_d = SAlphaHi;
      end
      SAlphaHi: begin
        num_d   = {17'd0, prod[40:0]};
        mul_a_d = alpha_q;
        mul_b_d = {7'd0, sum_q[33:17]};
        state_d = SAlphaAcc;
      end
      SAlphaAcc: begin
        num_d   = num_q + {prod[40:0], 17'd0};
        state_d = SDivStart;
      end
      SDivStart: begin
        div_start = 1'b1;
        state_d   = SDivWait;
      end
      SDivWait: begin
        if (div_done) begin
          state_d = SDen;
        end
      end
      SDen: begin
        den_d   = {11'd0, bias_q, 24'd0} + {1'b0, div_quo};
        p_d     = 6'd58;
        state_d = SNorm;
      end
      SNorm: begin
        if (den_q == 59'd0) begin
          if (beta_q == 16'd0) begin
            q_d     = '0;
            state_d = SExpI;
          end else begin
            zden_d  = 1'b1;
            state_d = SOut;
          end
        end else if (den_q[58:51] == 8'd0) begin
          den_d = {den_q[50:0], 8'd0};
          p_d   = p_q - 6'd8;
        end else if (!den_q[58]) begin
          den_d = {den_q[57:0], 1'b0};
          p_d   = p_q - 6'd1;
        end else begin
          mul_a_d = {11'd0, log_diff[12:0]};
          mul_b_d = {8'd0, den_q[53:38]};
          state_d = SLog;
        end
      end
      SLog: begin
        l_d     = $signed({p_m40, 16'd0}) + $signed({6'd0, lf});
        state_d = SBeta;
      end
      SBeta: begin
        mul_a_d = {8'd0, beta_q};
        mul_b_d = {2'd0, l_abs_s[21:0]};
        state_d = SQuot;
      end
      SQuot: begin
        q_d     = t_val[38:14];
        state_d = SExpI;
      end
      SExpI: begin
        mul_a_d = {11'd0, exp_diff[12:0]};
        mul_b_d = {12'd0, q_q[11:0]};
        state_d = SExpR;
      end
      SExpR: begin
        e_d     = exp_lo[16:0] + {4'd0, prod[24:12]};
        state_d = SMag;
      end
      SMag: begin
        mul_a_d = {8'd0, rd_abs};
        mul_b_d = {7'd0, e_q};
        state_d = SScale;
      end
      // Hold the scaled magnitude so rounding starts from a register.
      SScale: begin
        mag_d   = prod[32:0];
        state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = res;
          out_last_d   = last_q && (d_q == 4'd0);
          out_sat_d    = res_sat;
          if (last_q && (pend_q != 4'd0)) begin
            d_d     = pend_q - 4'd1;
            pend_d  = pend_q - 4'd1;
            state_d = SSetup;
          end else begin
            if (last_q) begin
              hist_d = 4'd0;
            end
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pend_q      <= '0;
      hist_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= lrn_pkg::WindowReset;
      alpha_q     <= lrn_pkg::AlphaReset;
      beta_q      <= lrn_pkg::BetaReset;
      bias_q      <= lrn_pkg::BiasReset;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      hist_q      <= hist_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (lrn_pkg::cfg_idx_e'(cfg_idx_i))
          lrn_pkg::CfgWindow: win_q   <= cfg_data_i[3:0];
          lrn_pkg::CfgAlpha:  alpha_q <= cfg_data_i;
          lrn_pkg::CfgBeta:   beta_q  <= cfg_data_i[15:0];
          lrn_pkg::CfgBias:   bias_q  <= cfg_data_i;
          default:            win_q   <= win_q;
        endcase
      end
    end
  end

  // Datapath registers and the sample shift line.
  always_ff @(posedge clk_i) begin
    if (ring_shift) begin
      for (int i = lrn_pkg::MaxWindow - 1; i > 0; i--) begin
        ring_q[i] <= ring_q[i-1];
      end
      ring_q[0] <= in_sample_i;
    end
    d_q          <= d_d;
    idx_q        <= idx_d;
    end_q        <= end_d;
    sum_q        <= sum_d;
    mul_a_q      <= mul_a_d;
    mul_b_q      <= mul_b_d;
    num_q        <= num_d;
    den_q        <= den_d;
    p_q          <= p_d;
    l_q          <= l_d;
    q_q          <= q_d;
    e_q          <= e_d;
    mag_q        <= mag_d;
    zden_q       <= zden_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
    out_sat_q    <= out_sat_d;
  end

  // Division of the scaled square sum by the window size.
  lrn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o   = (state_q == SIdle);
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;
  assign saturated_o  = out_sat_q;

  // The sum never runs past the end of its window or the store.
  a_tap_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSumA) |-> ((idx_q <= end_q) && (idx_q < 4'(lrn_pkg::MaxWindow))))
    else $error("window tap index beyond window end");

  // The divider only finishes while the sequencer is waiting for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == SDivWait))
    else $error("divider finished outside its wait step");

  // The word marked last leaves no channel of the vector held back.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SOut) && out_valid_d && last_q && (d_q == 4'd0)
     && (!out_valid_q || out_ready_i)) |-> (pend_q == 4'd0))
    else $error("last word emitted with channels still held");

  // A pass that loads the output register returns to idle or starts the next flush.
  a_out_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SOut) && (!out_valid_q || out_ready_i))
    |=> (out_valid_q && ((state_q == SIdle) || (state_q == SSetup))))
    else $error("output step did not complete cleanly");

endmodule

// ===== rtl/lrn_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window-size division.
`timescale 1ns / 1ps

module lrn_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lrn_pkg::NumWidth-1:0]         dividend_i,
  input  logic [lrn_pkg::DivisorWidth-1:0]     divisor_i,
  output logic                                 done_o,
  output logic [lrn_pkg::NumWidth-1:0]         quotient_o
);

  logic                                 busy_q;
  logic                                 done_q;
  logic [lrn_pkg::DivCntWidth-1:0]      cnt_q;
  logic [lrn_pkg::NumWidth-1:0]         quo_q;
  logic [lrn_pkg::DivisorWidth-1:0]     rem_q;
  logic [lrn_pkg::DivisorWidth:0]       rem_sh;
  logic [lrn_pkg::DivisorWidth:0]       rem_diff;
  logic                                 ge;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    rem_sh   = {rem_q, quo_q[lrn_pkg::NumWidth-1]};
    ge       = rem_sh >= {1'b0, divisor_i};
    rem_diff = rem_sh - {1'b0, divisor_i};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == lrn_pkg::DivCntWidth'(lrn_pkg::NumWidth - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient bits shift in as the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[lrn_pkg::NumWidth-2:0], ge};
      rem_q <= ge ? rem_diff[lrn_pkg::DivisorWidth-1:0] : rem_sh[lrn_pkg::DivisorWidth-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sim/local_response_norm_channel_tb.sv =====
// Self-checking testbench for the cross-channel local response normaliser.
`timescale 1ns / 1ps

module local_response_norm_channel_tb;

  // One input word and one normalised output word.
  typedef struct {
    lrn_pkg::sample_t smp;
    logic             last;
  } chan_word_t;

  typedef struct {
    lrn_pkg::sample_t smp;
    logic             last;
    logic             sat;
  } norm_word_t;

  // Knots of the log2 and exp2 approximations, Q16.
  localparam longint unsigned Log2Knot [17] = '{
    0, 5732, 11136, 16253, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
  localparam longint unsigned Exp2Knot [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
    96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [1:0]                   cfg_idx_i = '0;
  logic [lrn_pkg::CfgWidth-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  lrn_pkg::sample_t             in_sample_i = '0;
  logic                         last_channel_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  lrn_pkg::sample_t             out_sample_o;
  logic                         out_last_o;
  logic                         saturated_o;

  local_response_norm_channel dut (.*);

  // Pending stimulus, expected outputs and the predictor's own state.
  chan_word_t       feed_q[$];
  norm_word_t       norm_q[$];
  lrn_pkg::sample_t hist_ring [lrn_pkg::MaxWindow];
  int unsigned held_cnt = 0;
  int unsigned hist_cnt = 0;
  logic [3:0]  win_reg = lrn_pkg::WindowReset;
  logic [23:0] alpha_reg = lrn_pkg::AlphaReset;
  logic [15:0] beta_reg = lrn_pkg::BetaReset;
  logic [23:0] bias_reg = lrn_pkg::BiasReset;

  int unsigned err_cnt = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned sat_seen = 0;
  int unsigned phase_cnt = 0;
  bit          no_idle = 1'b0;
  bit          in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, none during phases with no_idle set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (output word %0d)", what, got, want,
             words_out);
    err_cnt++;
  endtask

  // log2 of the Q.40 denominator in Q16.
  function automatic longint log2_q16(input longint unsigned d);
    int p;
    longint unsigned nrm, frac, r, lf;
    int unsigned i;
    p = 63;
    while (p > 0 && !d[p]) p--;
    nrm = d << (63 - p);
    frac = (nrm >> 43) & 64'hF_FFFF;
    i = 32'(frac >> 16);
    r = frac & 64'hFFFF;
    lf = Log2Knot[i] + (((Log2Knot[i+1] - Log2Knot[i]) * r) >> 16);
    return (longint'(p) - 40) * 65536 + longint'(lf);
  endfunction

  // Normalise the held channel at depth d of the ring.
  function automatic norm_word_t normalise(input int unsigned d, input int unsigned n,
                                           input logic last);
    int unsigned hlo, hhi, below, lo, up, i;
    longint unsigned sum, den, e, mag, lim, m, f;
    longint x, v, q, k, s, res;
    norm_word_t w;
    hlo = (n - 1) / 2;
    hhi = n / 2;
    below = (hist_cnt > d) ? hist_cnt - 1 - d : 0;
    lo = (below < hlo) ? below : hlo;
    up = (d < hhi) ? d : hhi;
    sum = 0;
    for (i = d - up; i <= d + lo && i < lrn_pkg::MaxWindow; i++) begin
      v = hist_ring[i];
      sum += longint'(v * v);
    end
    x = hist_ring[d];
    den = (longint'(bias_reg) << 24) + (longint'(alpha_reg) * sum) / n;
    w.last = last;
    w.sat = 1'b0;
    if (den == 0 && beta_reg != 0) begin
      res = x > 0 ? 32767 : (x < 0 ? -32768 : 0);
      w.sat = 1'b1;
    end else begin
      q = 0;
      if (den != 0) q = (-(longint'(beta_reg) * log2_q16(den))) >>> 14;
      k = q >>> 16;
      f = q - k * 65536;
      i = 32'(f >> 12);
      e = Exp2Knot[i] + (((Exp2Knot[i+1] - Exp2Knot[i]) * (f & 64'hFFF)) >> 12);
      mag = longint'(x < 0 ? -x : x) * e;
      lim = x < 0 ? 32768 : 32767;
      s = 16 - k;
      if (mag == 0) m = 0;
      else if (s <= 0) m = (-s >= 24) ? lim + 1 : mag << (-s);
      else if (s >= 64) m = 0;
      else m = (mag + (64'd1 << (s - 1))) >> s;
      if (m > lim) begin
        m = lim;
        w.sat = 1'b1;
      end
      res = x < 0 ? -longint'(m) : longint'(m);
    end
    w.smp = lrn_pkg::sample_t'(res);
    return w;
  endfunction

  // Advance the predicted state by one accepted channel word.
  task automatic predict_norm(input chan_word_t cw);
    int unsigned n;
    n = (win_reg == 0) ? 1 : win_reg;
    for (int i = lrn_pkg::MaxWindow - 1; i > 0; i--) hist_ring[i] = hist_ring[i-1];
    hist_ring[0] = cw.smp;
    if (hist_cnt < lrn_pkg::MaxWindow) hist_cnt++;
    held_cnt++;
    if (cw.last) begin
      while (held_cnt > 0) begin
        held_cnt--;
        norm_q.push_back(normalise(held_cnt, n, held_cnt == 0));
      end
      hist_cnt = 0;
    end else if (held_cnt > n / 2) begin
      held_cnt--;
      norm_q.push_back(normalise(held_cnt, n, 1'b0));
    end
  endtask

  // Input driver: holds a word until it is taken, then idles or sends the next; also gaps out_ready_i.
  always @(negedge clk_i) begin
    chan_word_t cw;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (feed_q.size() > 0) begin
        cw = feed_q.pop_front();
        in_valid_i <= 1'b1;
        in_sample_i <= cw.smp;
        last_channel_i <= cw.last;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted outputs.
  always @(posedge clk_i) begin
    norm_word_t w;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_norm('{smp: in_sample_i, last: last_channel_i});
      words_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (saturated_o) sat_seen++;
      if (norm_q.size() == 0) begin
        report("unexpected word", out_sample_o, 0);
      end else begin
        w = norm_q.pop_front();
        if (out_sample_o !== w.smp) report("out_sample", out_sample_o, w.smp);
        if (out_last_o !== w.last) report("out_last", out_last_o, w.last);
        if (saturated_o !== w.sat) report("saturated", saturated_o, w.sat);
      end
    end
  end

  // Register write, mirrored into the predictor at the same edge.
  task automatic write_reg(input lrn_pkg::cfg_idx_e idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      lrn_pkg::CfgWindow: win_reg = val[3:0];
      lrn_pkg::CfgAlpha:  alpha_reg = val;
      lrn_pkg::CfgBeta:   beta_reg = val[15:0];
      lrn_pkg::CfgBias:   bias_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [3:0] n, input logic [23:0] a, input logic [15:0] b,
                          input logic [23:0] c);
    write_reg(lrn_pkg::CfgWindow, 24'(n));
    write_reg(lrn_pkg::CfgAlpha, a);
    write_reg(lrn_pkg::CfgBeta, 24'(b));
    write_reg(lrn_pkg::CfgBias, c);
  endtask

  // Wait until every word has gone through, then allow for a pass still running.
  task automatic drain();
    while (feed_q.size() > 0 || in_valid_i || norm_q.size() > 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    phase_cnt++;
  endtask

  // Queue one channel vector; kind 0 full range, 1 small values, 2 extremes.
  task automatic add_vector(input int unsigned len, input int unsigned kind, input bit close);
    chan_word_t cw;
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0: cw.smp = lrn_pkg::sample_t'($urandom);
        1: cw.smp = lrn_pkg::sample_t'($signed($urandom_range(0, 2047)) - 1024);
        default: cw.smp = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      endcase
      cw.last = close && (i == len - 1);
      feed_q.push_back(cw);
    end
  endtask

  task automatic push_word(input int s, input logic l);
    feed_q.push_back('{smp: lrn_pkg::sample_t'(s), last: l});
  endtask

  function automatic logic [23:0] pick24(input logic [23:0] dflt);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 24'hFF_FFFF;
      2: return dflt;
      3: return 24'($urandom_range(0, 4095));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned kind;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes, a one-channel vector and a mixed vector.
    push_word(32767, 0); push_word(-32768, 0); push_word(0, 0); push_word(1, 0);
    push_word(-1, 0); push_word(16'h5555, 0); push_word(-21846, 1);
    push_word(-300, 1);
    drain();

    // Zero denominator with beta set, then with beta clear.
    set_regs(4'd3, 24'd0, 16'hFFFF, 24'd0);
    push_word(100, 0); push_word(-100, 0); push_word(0, 1);
    drain();
    write_reg(lrn_pkg::CfgBeta, 24'd0);
    push_word(-32768, 0); push_word(0, 0); push_word(32767, 1);
    drain();

    // Window zero acts as one; largest window over a vector longer than the ring.
    set_regs(4'd0, 24'hFF_FFFF, 16'd12288, 24'd65536);
    add_vector(3, 1, 1'b1);
    drain();
    set_regs(4'd15, 24'd1678, 16'hFFFF, 24'd1);
    add_vector(18, 0, 1'b1);
    drain();

    // Window changed in the middle of a vector.
    write_reg(lrn_pkg::CfgWindow, 24'd1);
    add_vector(3, 1, 1'b0);
    drain();
    write_reg(lrn_pkg::CfgWindow, 24'd9);
    add_vector(4, 0, 1'b1);
    drain();

    // Random settings per phase, vectors of random length and content.
    while (words_in + feed_q.size() < 310) begin
      set_regs(4'($urandom_range(0, 15)), pick24(lrn_pkg::AlphaReset),
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF) :
                                             16'($urandom),
               pick24(lrn_pkg::BiasReset));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int v = 0; v < 4; v++) begin
        kind = $urandom_range(0, 9);
        add_vector(($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8),
                   kind < 5 ? 0 : (kind < 9 ? 1 : 2), ($urandom_range(0, 9) != 0));
      end
      drain();
      no_idle = 1'b0;
    end
    // Close any vector left open by the random part.
    push_word(7, 1);
    drain();

    $display("Checked %0d output words from %0d channel words over %0d phases.",
             words_out, words_in, phase_cnt);
    $display("Saturated outputs seen: %0d; mismatches: %0d.", sat_seen, err_cnt);
    if (err_cnt == 0 && norm_q.size() == 0) begin
      $display("local_response_norm_channel_tb passed");
    end else begin
      $display("local_response_norm_channel_tb failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d output words still expected.", norm_q.size());
    $display("local_response_norm_channel_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lrn_pkg.sv
rtl/lrn_div.sv
rtl/local_response_norm_channel.sv
sim/local_response_norm_channel_tb.sv
